FILE: rtl/pvad_pkg.sv
// shared types and codes for the forward-difference differencer
package pvad_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // item class, assigned by the front end from the fill level of the set
    localparam logic [1:0] K_FIRST = 2'd0;
    localparam logic [1:0] K_PAIR  = 2'd1;
    localparam logic [1:0] K_RUN   = 2'd2;

    // record status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       eos;
    } tag_t;

endpackage

FILE: rtl/pvad_front.sv
// front end: accepts samples and tags them with their place in the set
module pvad_front import pvad_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_sample_time,
    input  logic [DATA_WIDTH-1:0] s_position,
    input  logic                  s_end_of_set,
    input  logic                  q_full,
    output logic                  q_push,
    output tag_t                  q_tag,
    output logic [DATA_WIDTH-1:0] q_time,
    output logic [DATA_WIDTH-1:0] q_pos
);

    logic [1:0] fill_reg, fill_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign q_time  = s_sample_time;
    assign q_pos   = s_position;

    always_comb begin
        q_tag.eos = s_end_of_set;
        unique case (fill_reg)
            2'd0:    q_tag.kind = K_FIRST;
            2'd1:    q_tag.kind = K_PAIR;
            default: q_tag.kind = K_RUN;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (q_push) begin
            if (s_end_of_set) begin
                fill_next = 2'd0;
            end else if (fill_reg != 2'd2) begin
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: rtl/pvad_queue.sv
// short queue between front end and back end
module pvad_queue import pvad_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tag_t                  push_tag,
    input  logic [DATA_WIDTH-1:0] push_time,
    input  logic [DATA_WIDTH-1:0] push_pos,
    output logic                  full,
    output logic                  not_empty,
    input  logic                  pop,
    output tag_t                  pop_tag,
    output logic [DATA_WIDTH-1:0] pop_time,
    output logic [DATA_WIDTH-1:0] pop_pos
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tag_t                  tag_mem  [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] time_mem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] pos_mem  [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_tag   = tag_mem[rd_ptr_reg];
    assign pop_time  = time_mem[rd_ptr_reg];
    assign pop_pos   = pos_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            tag_mem[wr_ptr_reg]  <= push_tag;
            time_mem[wr_ptr_reg] <= push_time;
            pos_mem[wr_ptr_reg]  <= push_pos;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

FILE: rtl/pvad_div.sv
// radix-2 signed divider, truncating toward zero, saturating to the data width
module pvad_div import pvad_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DATA_WIDTH:0]   num,
    input  logic [DATA_WIDTH:0]   den,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quot,
    output logic                  sat
);

    localparam int N  = DATA_WIDTH + 1;
    localparam int CW = $clog2(N + 1);
    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic          busy_reg, busy_next, fin_reg, fin_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  rem_reg, rem_next, quo_reg, quo_next, dmag_reg, dmag_next;
    logic          neg_reg, neg_next, dz_reg, dz_next;
    logic          nneg_reg, nneg_next, nz_reg, nz_next;

    logic [N:0]    shifted;
    logic [N+1:0]  diff;
    logic          big;

    assign shifted = {rem_reg, quo_reg[N-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dmag_reg};

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        nneg_next = nneg_reg;
        nz_next   = nz_reg;
        if (start) begin
            neg_next  = num[N-1] ^ den[N-1];
            dz_next   = (den == '0);
            nneg_next = num[N-1];
            nz_next   = (num != '0);
            rem_next  = '0;
            quo_next  = num[N-1] ? (~num + 1'b1) : num;
            dmag_next = den[N-1] ? (~den + 1'b1) : den;
            cnt_next  = CW'(N);
            if (den == '0) begin
                fin_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (!diff[N+1]) begin
                rem_next = diff[N-1:0];
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = shifted[N-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
        nneg_reg <= nneg_next;
        nz_reg   <= nz_next;
    end

    // sign and saturation of the finished magnitude
    always_comb begin
        big = 1'b0;
        if (dz_reg) begin
            sat  = 1'b1;
            quot = nz_reg ? (nneg_reg ? MINV : MAXV) : '0;
        end else if (!neg_reg) begin
            big  = |quo_reg[N-1:DATA_WIDTH-1];
            sat  = big;
            quot = big ? MAXV : quo_reg[DATA_WIDTH-1:0];
        end else begin
            big  = quo_reg > {1'b0, MINV};
            sat  = big;
            quot = big ? MINV : (~quo_reg[DATA_WIDTH-1:0] + 1'b1);
        end
    end

    assign done = fin_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg && !fin_reg)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |=> !fin_reg)
        else $error("divider done held");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> fin_reg)
        else $error("divider stopped without result");
`endif

endmodule

FILE: rtl/pvad_back.sv
// back end: history, up to two divisions per sample, and record output
module pvad_back import pvad_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  tag_t                  q_tag,
    input  logic [DATA_WIDTH-1:0] q_time,
    input  logic [DATA_WIDTH-1:0] q_pos,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_out_time,
    output logic [DATA_WIDTH-1:0] m_out_position,
    output logic [DATA_WIDTH-1:0] m_velocity,
    output logic [DATA_WIDTH-1:0] m_acceleration,
    output logic [1:0]            m_status,
    output logic                  m_last_of_run
);

    localparam int W = DATA_WIDTH;

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_DECODE = 3'd1;
    localparam logic [2:0] B_DIV1   = 3'd2;
    localparam logic [2:0] B_DIV2S  = 3'd3;
    localparam logic [2:0] B_DIV2   = 3'd4;
    localparam logic [2:0] B_EMIT   = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [1:0]   rec_reg, rec_next;
    tag_t         wtag_reg, wtag_next;
    logic [W-1:0] wtime_reg, wtime_next, wpos_reg, wpos_next;
    logic [W-1:0] th0_reg, th0_next, th1_reg, th1_next;
    logic [W-1:0] xh0_reg, xh0_next, xh1_reg, xh1_next;
    logic [W-1:0] ov_reg, ov_next, vel_reg, vel_next, acc_reg, acc_next;
    logic         ovs_reg, ovs_next, sv_reg, sv_next, sa_reg, sa_next;

    logic         ov_valid_reg, ov_valid_next;
    logic [W-1:0] o_time_reg, o_pos_reg, o_vel_reg, o_acc_reg;
    logic [1:0]   o_status_reg;
    logic         o_last_reg;

    logic         div_start, div_done, div_sat;
    logic [W:0]   div_num, div_den;
    logic [W-1:0] div_q;

    logic         out_free, load_out, final_rec, last_rec;
    logic [1:0]   rec_total;
    logic [W-1:0] r_time, r_pos, r_vel, r_acc;
    logic [1:0]   r_status;

    pvad_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q),
        .sat     (div_sat)
    );

    // velocity division uses the newest held sample, acceleration the velocity gap
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (state_reg == B_DECODE && wtag_reg.kind != K_FIRST) begin
            div_start = 1'b1;
            if (wtag_reg.kind == K_PAIR) begin
                div_num = {wpos_reg[W-1], wpos_reg} - {xh0_reg[W-1], xh0_reg};
                div_den = {1'b0, wtime_reg} - {1'b0, th0_reg};
            end else begin
                div_num = {wpos_reg[W-1], wpos_reg} - {xh1_reg[W-1], xh1_reg};
                div_den = {1'b0, wtime_reg} - {1'b0, th1_reg};
            end
        end else if (state_reg == B_DIV2S) begin
            div_start = 1'b1;
            div_num   = {vel_reg[W-1], vel_reg} - {ov_reg[W-1], ov_reg};
            div_den   = {1'b0, th1_reg} - {1'b0, th0_reg};
        end
    end

    always_comb begin
        case (wtag_reg.kind)
            K_FIRST: rec_total = 2'd1;
            K_PAIR:  rec_total = 2'd2;
            default: rec_total = wtag_reg.eos ? 2'd3 : 2'd1;
        endcase
        last_rec  = (rec_reg == rec_total - 2'd1);
        final_rec = last_rec && wtag_reg.eos;
        if (final_rec) begin
            r_time = wtime_reg;
            r_pos  = wpos_reg;
        end else if (rec_reg == 2'd0) begin
            r_time = th0_reg;
            r_pos  = xh0_reg;
        end else begin
            r_time = th1_reg;
            r_pos  = xh1_reg;
        end
        r_acc = '0;
        if (wtag_reg.kind == K_FIRST) begin
            r_vel    = '0;
            r_status = ST_SHORT;
        end else if (wtag_reg.kind == K_RUN && rec_reg == 2'd0) begin
            r_vel    = ov_reg;
            r_acc    = acc_reg;
            r_status = (ovs_reg || sa_reg) ? ST_SAT : ST_OK;
        end else begin
            r_vel    = vel_reg;
            r_status = sv_reg ? ST_SAT : ST_OK;
        end
    end

    assign out_free = !ov_valid_reg || m_ready;
    assign load_out = (state_reg == B_EMIT) && out_free;
    assign q_pop    = (state_reg == B_IDLE) && q_valid;

    always_comb begin
        state_next = state_reg;
        rec_next   = rec_reg;
        wtag_next  = wtag_reg;
        wtime_next = wtime_reg;
        wpos_next  = wpos_reg;
        th0_next   = th0_reg;
        th1_next   = th1_reg;
        xh0_next   = xh0_reg;
        xh1_next   = xh1_reg;
        ov_next    = ov_reg;
        ovs_next   = ovs_reg;
        vel_next   = vel_reg;
        sv_next    = sv_reg;
        acc_next   = acc_reg;
        sa_next    = sa_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    wtag_next  = q_tag;
                    wtime_next = q_time;
                    wpos_next  = q_pos;
                    rec_next   = 2'd0;
                    state_next = B_DECODE;
                end
            end
            B_DECODE: begin
                if (wtag_reg.kind == K_FIRST) begin
                    if (wtag_reg.eos) begin
                        state_next = B_EMIT;
                    end else begin
                        th0_next   = wtime_reg;
                        xh0_next   = wpos_reg;
                        state_next = B_IDLE;
                    end
                end else begin
                    state_next = B_DIV1;
                end
            end
            B_DIV1: begin
                if (div_done) begin
                    vel_next = div_q;
                    sv_next  = div_sat;
                    if (wtag_reg.kind == K_RUN) begin
                        state_next = B_DIV2S;
                    end else if (wtag_reg.eos) begin
                        state_next = B_EMIT;
                    end else begin
                        ov_next    = div_q;
                        ovs_next   = div_sat;
                        th1_next   = wtime_reg;
                        xh1_next   = wpos_reg;
                        state_next = B_IDLE;
                    end
                end
            end
            B_DIV2S: begin
                state_next = B_DIV2;
            end
            B_DIV2: begin
                if (div_done) begin
                    acc_next   = div_q;
                    sa_next    = div_sat;
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    rec_next = rec_reg + 2'd1;
                    if (last_rec) begin
                        state_next = B_IDLE;
                        if (!wtag_reg.eos) begin
                            th0_next = th1_reg;
                            xh0_next = xh1_reg;
                            th1_next = wtime_reg;
                            xh1_next = wpos_reg;
                            ov_next  = vel_reg;
                            ovs_next = sv_reg;
                        end
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        ov_valid_next = ov_valid_reg;
        if (load_out) begin
            ov_valid_next = 1'b1;
        end else if (m_ready) begin
            ov_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            rec_reg      <= 2'd0;
            ov_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rec_reg      <= rec_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wtag_reg  <= wtag_next;
        wtime_reg <= wtime_next;
        wpos_reg  <= wpos_next;
        th0_reg   <= th0_next;
        th1_reg   <= th1_next;
        xh0_reg   <= xh0_next;
        xh1_reg   <= xh1_next;
        ov_reg    <= ov_next;
        ovs_reg   <= ovs_next;
        vel_reg   <= vel_next;
        sv_reg    <= sv_next;
        acc_reg   <= acc_next;
        sa_reg    <= sa_next;
        if (load_out) begin
            o_time_reg   <= r_time;
            o_pos_reg    <= r_pos;
            o_vel_reg    <= r_vel;
            o_acc_reg    <= r_acc;
            o_status_reg <= r_status;
            o_last_reg   <= final_rec;
        end
    end

    assign m_valid        = ov_valid_reg;
    assign m_out_time     = o_time_reg;
    assign m_out_position = o_pos_reg;
    assign m_velocity     = o_vel_reg;
    assign m_acceleration = o_acc_reg;
    assign m_status       = o_status_reg;
    assign m_last_of_run  = o_last_reg;

`ifndef SYNTHESIS
    a_pop_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == B_DECODE)
        else $error("popped item not decoded");
    a_rec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_EMIT |-> rec_reg < rec_total)
        else $error("record index past end of item");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == B_DIV1 || state_reg == B_DIV2)
        else $error("division result with no one waiting");
`endif

endmodule

FILE: rtl/position_velocity_accel_differencer_core.sv
// top level: forward-difference velocity and acceleration of a sample stream
// latency: a sample's record leaves two samples later
// throughput: one item per back-end pass; both divisions share one radix-2
//   divider, one quotient bit per cycle, which sets the rate
// reset: aresetn synchronous active low clears the fill count, queue and handshakes
module position_velocity_accel_differencer_core import pvad_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_sample_time,
    input  logic [DATA_WIDTH-1:0] s_position,
    input  logic                  s_end_of_set,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_out_time,
    output logic [DATA_WIDTH-1:0] m_out_position,
    output logic [DATA_WIDTH-1:0] m_velocity,
    output logic [DATA_WIDTH-1:0] m_acceleration,
    output logic [1:0]            m_status,
    output logic                  m_last_of_run
);

    // front to queue
    logic                  push, q_full;
    tag_t                  push_tag;
    logic [DATA_WIDTH-1:0] push_time, push_pos;

    // queue to back
    logic                  q_valid, q_pop;
    tag_t                  pop_tag;
    logic [DATA_WIDTH-1:0] pop_time, pop_pos;

    // front tags each beat as first, second or later sample of its set
    pvad_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_time (s_sample_time),
        .s_position    (s_position),
        .s_end_of_set  (s_end_of_set),
        .q_full        (q_full),
        .q_push        (push),
        .q_tag         (push_tag),
        .q_time        (push_time),
        .q_pos         (push_pos)
    );

    // decouples input acceptance from the long divide passes
    pvad_queue #(.DATA_WIDTH(DATA_WIDTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_tag  (push_tag),
        .push_time (push_time),
        .push_pos  (push_pos),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .pop_tag   (pop_tag),
        .pop_time  (pop_time),
        .pop_pos   (pop_pos)
    );

    // back end holds history, divides, and drives the output register
    pvad_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_tag          (pop_tag),
        .q_time         (pop_time),
        .q_pos          (pop_pos),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_time     (m_out_time),
        .m_out_position (m_out_position),
        .m_velocity     (m_velocity),
        .m_acceleration (m_acceleration),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

FILE: tb/sv/pvad_checker.sv
// scoreboard that predicts differencer records and compares them with the result channel
module pvad_checker import pvad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_sample_time,
    input  logic [31:0] s_position,
    input  logic        s_end_of_set,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_out_time,
    input  logic [31:0] m_out_position,
    input  logic [31:0] m_velocity,
    input  logic [31:0] m_acceleration,
    input  logic [1:0]  m_status,
    input  logic        m_last_of_run,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [1:0]  status;
        logic        last;
    } record_t;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    record_t     record_q[$];
    logic [31:0] hist_t[2];
    longint      hist_x[2];
    longint      prev_vel;
    logic        prev_vel_sat;
    int          held;

    assign pending_count = record_q.size();

    function automatic longint quotient(longint num, longint den, inout logic sat);
        longint q;
        if (den == 0) begin
            sat = 1'b1;
            return num > 0 ? QMAX : (num < 0 ? QMIN : 0);
        end
        q = num / den;
        if (q > QMAX) begin
            sat = 1'b1;
            return QMAX;
        end
        if (q < QMIN) begin
            sat = 1'b1;
            return QMIN;
        end
        return q;
    endfunction

    function automatic longint tick_step(logic [31:0] from, logic [31:0] to);
        return longint'({32'd0, to}) - longint'({32'd0, from});
    endfunction

    function automatic void push_record(logic [31:0] t, longint x, longint v, longint a,
                                        logic [1:0] st, logic last);
        record_t r;
        r.t = t;
        r.x = x[31:0];
        r.vel = v[31:0];
        r.acc = a[31:0];
        r.status = st;
        r.last = last;
        record_q.insert(record_q.size(), r);
    endfunction

    function automatic void clear_set();
        hist_t[0] = '0;
        hist_t[1] = '0;
        hist_x[0] = 0;
        hist_x[1] = 0;
        prev_vel = 0;
        prev_vel_sat = 1'b0;
        held = 0;
    endfunction

    function automatic void predict_sample(logic [31:0] t, logic [31:0] xr, logic eos);
        longint x, dt, vel, acc, acc_end;
        logic sv, sa, sb;
        x = longint'(signed'(xr));
        sv = 1'b0;
        sa = 1'b0;
        sb = 1'b0;
        if (held == 0) begin
            if (eos) begin
                push_record(t, x, 0, 0, ST_SHORT, 1'b1);
                clear_set();
            end else begin
                hist_t[0] = t;
                hist_x[0] = x;
                held = 1;
            end
        end else if (held == 1) begin
            dt = tick_step(hist_t[0], t);
            vel = quotient(x - hist_x[0], dt, sv);
            if (eos) begin
                acc = quotient(0, dt, sa);
                push_record(hist_t[0], hist_x[0], vel, acc, (sv || sa) ? ST_SAT : ST_OK, 1'b0);
                push_record(t, x, vel, acc, (sv || sa) ? ST_SAT : ST_OK, 1'b1);
                clear_set();
            end else begin
                prev_vel = vel;
                prev_vel_sat = sv;
                hist_t[1] = t;
                hist_x[1] = x;
                held = 2;
            end
        end else begin
            dt = tick_step(hist_t[1], t);
            vel = quotient(x - hist_x[1], dt, sv);
            acc = quotient(vel - prev_vel, tick_step(hist_t[0], hist_t[1]), sa);
            push_record(hist_t[0], hist_x[0], prev_vel, acc,
                        (prev_vel_sat || sa) ? ST_SAT : ST_OK, 1'b0);
            if (eos) begin
                acc_end = quotient(0, dt, sb);
                push_record(hist_t[1], hist_x[1], vel, acc_end,
                            (sv || sb) ? ST_SAT : ST_OK, 1'b0);
                push_record(t, x, vel, acc_end, (sv || sb) ? ST_SAT : ST_OK, 1'b1);
                clear_set();
            end else begin
                hist_t[0] = hist_t[1];
                hist_x[0] = hist_x[1];
                hist_t[1] = t;
                hist_x[1] = x;
                prev_vel = vel;
                prev_vel_sat = sv;
            end
        end
    endfunction

    initial begin
        fail_count = 0;
        clear_set();
    end

    always @(posedge aclk) begin
        record_t got, want;
        if (!aresetn) begin
            clear_set();
        end else begin
            if (s_valid && s_ready)
                predict_sample(s_sample_time, s_position, s_end_of_set);
            if (m_valid && m_ready) begin
                got = '{m_out_time, m_out_position, m_velocity, m_acceleration,
                        m_status, m_last_of_run};
                if (record_q.size() == 0) begin
                    $display("%0t: unexpected record expected none actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = record_q.pop_front();
                    if (got.t !== want.t) begin
                        $display("%0t: out_time expected %h actual %h", $time, want.t, got.t);
                        fail_count++;
                    end
                    if (got.x !== want.x) begin
                        $display("%0t: out_position expected %h actual %h", $time, want.x, got.x);
                        fail_count++;
                    end
                    if (got.vel !== want.vel) begin
                        $display("%0t: velocity expected %h actual %h", $time, want.vel, got.vel);
                        fail_count++;
                    end
                    if (got.acc !== want.acc) begin
                        $display("%0t: acceleration expected %h actual %h", $time, want.acc,
                                 got.acc);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 got.status);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                                 got.last);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/testbench.sv
// top of the differencer testbench: clock, reset, sample stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pvad_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_sample_time;
    logic [31:0] s_position;
    logic        s_end_of_set;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_time;
    logic [31:0] m_out_position;
    logic [31:0] m_velocity;
    logic [31:0] m_acceleration;
    logic [1:0]  m_status;
    logic        m_last_of_run;
    int          fail_count;
    int          pending_count;

    // idle percentages per side, changed between phases
    int          send_idle_pct;
    int          recv_idle_pct;
    // running timestamp for well-formed sets
    logic [31:0] clock_ticks;

    position_velocity_accel_differencer_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_time  (s_sample_time),
        .s_position     (s_position),
        .s_end_of_set   (s_end_of_set),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_time     (m_out_time),
        .m_out_position (m_out_position),
        .m_velocity     (m_velocity),
        .m_acceleration (m_acceleration),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run)
    );

    pvad_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_time  (s_sample_time),
        .s_position     (s_position),
        .s_end_of_set   (s_end_of_set),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_time     (m_out_time),
        .m_out_position (m_out_position),
        .m_velocity     (m_velocity),
        .m_acceleration (m_acceleration),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: ready toggles at the falling edge with the current stall rate
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one beat on the sample channel; optional idle gap first, then hold until accepted
    // valid stays up after the accepting edge until the next call or drain decides
    task automatic send_sample(logic [31:0] t, logic [31:0] x, logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_time <= t;
        s_position    <= x;
        s_end_of_set  <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // random well-formed set: mostly rising time and sane positions, some extreme values
    task automatic send_random_set(int len);
        logic [31:0] x;
        logic [31:0] step;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: step = 32'd0;
                1: step = $urandom;
                2: step = -$urandom_range(50, 1);
                default: step = $urandom_range(5000, 1);
            endcase
            clock_ticks = clock_ticks + step;
            if ($urandom_range(4) == 0)
                x = $urandom;
            else
                x = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            send_sample(clock_ticks, x, i == len - 1);
        end
    endtask

    // drop valid, then wait until every predicted record has been taken
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    initial begin
        s_valid       = 1'b0;
        s_sample_time = '0;
        s_position    = '0;
        s_end_of_set  = 1'b0;
        aresetn       = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 71;
        clock_ticks   = 32'd100;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // set too short: lone samples at the field extremes
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b1);
        // set of two, ordinary step
        send_sample(32'd10, 32'h0001_0000, 1'b0);
        send_sample(32'd12, 32'h0005_0000, 1'b1);
        // sets of two with zero time step: positive, negative and zero numerator
        send_sample(32'd50, 32'h0000_0000, 1'b0);
        send_sample(32'd50, 32'h0001_0000, 1'b1);
        send_sample(32'd50, 32'h0001_0000, 1'b0);
        send_sample(32'd50, 32'h0000_0000, 1'b1);
        send_sample(32'd7, 32'h1234_5678, 1'b0);
        send_sample(32'd7, 32'h1234_5678, 1'b1);
        // overflow of the quotient and time running backwards across the wrap
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
        // longer set with a zero step in the middle
        send_sample(32'd1000, 32'h0000_1000, 1'b0);
        send_sample(32'd1003, 32'hFFFF_0000, 1'b0);
        send_sample(32'd1003, 32'h0002_0000, 1'b0);
        send_sample(32'd1010, 32'h0003_0000, 1'b0);
        send_sample(32'd1020, 32'h0000_0000, 1'b1);

        // hold off the sender until the block is fully drained
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 71;
                recv_idle_pct = 29;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 60; ) begin
                int len;
                if ($urandom_range(9) == 0)
                    len = $urandom_range(2, 1);
                else
                    len = $urandom_range(10, 3);
                send_random_set(len);
                n += len;
            end
        end

        drain();
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // run limit: ~220 items at their worst with stalls plus gaps, taken many times over
    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/pvad_pkg.sv
rtl/pvad_front.sv
rtl/pvad_queue.sv
rtl/pvad_div.sv
rtl/pvad_back.sv
rtl/position_velocity_accel_differencer_core.sv
tb/sv/pvad_checker.sv
tb/sv/testbench.sv
